@@ src/hbsf_pkg.sv @@
// shared types and constants for the hdlc bit stuffing framer
package hbsf_pkg;

	localparam int DATA_W = 8;
	localparam int CNT_W = 3;
	localparam int RUN_W = 3;
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_AW = 1;
	localparam int QUEUE_CW = 2;

	localparam logic [DATA_W-1:0] FLAG_PATTERN = 8'h7E;
	localparam logic [CNT_W-1:0] MSB_INDEX = 3'd7;
	localparam logic [RUN_W-1:0] RUN_LIMIT = 3'd5;

	// result tdata bit positions
	localparam int TD_LINE_BIT = 0;
	localparam int TD_FLAG_BIT = 1;
	localparam int TD_STUFF_BIT = 2;

	// one classified byte waiting for the serializer
	typedef struct packed {
		logic [DATA_W-1:0] data_byte;
		logic              end_of_frame;
		logic              open_flag;
	} item_t;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_OPEN  = 5'b00010,
		ST_DATA  = 5'b00100,
		ST_STUFF = 5'b01000,
		ST_CLOSE = 5'b10000
	} state_t;

	// queue handshake between the front and back parts
	typedef struct packed {
		logic empty;
		logic full;
	} queue_status_t;

endpackage

@@ src/hbsf_front.sv @@
// front part: accepts bytes and marks the first byte of each frame
module hbsf_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic [hbsf_pkg::DATA_W-1:0]   in_byte,
	input  logic                          in_eof,
	input  hbsf_pkg::queue_status_t       qstat,
	output logic                          in_ready,
	output logic                          push,
	output hbsf_pkg::item_t               push_item
);

	logic in_frame_q;

	assign in_ready = !qstat.full;
	assign push = in_valid && in_ready;

	always_comb begin
		push_item.data_byte = in_byte;
		push_item.end_of_frame = in_eof;
		push_item.open_flag = !in_frame_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
		end else if (push) begin
			in_frame_q <= !in_eof;
		end
	end

endmodule

@@ src/hbsf_queue.sv @@
// short queue of classified bytes between front and back parts
module hbsf_queue (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  hbsf_pkg::item_t         push_item,
	input  logic                    pop,
	output hbsf_pkg::item_t         head,
	output hbsf_pkg::queue_status_t qstat
);

	hbsf_pkg::item_t                  entries_q [hbsf_pkg::QUEUE_DEPTH];
	logic [hbsf_pkg::QUEUE_AW-1:0]    wr_ptr_q;
	logic [hbsf_pkg::QUEUE_AW-1:0]    rd_ptr_q;
	logic [hbsf_pkg::QUEUE_CW-1:0]    count_q;

	assign head = entries_q[rd_ptr_q];
	assign qstat.empty = (count_q == '0);
	assign qstat.full = (count_q == hbsf_pkg::QUEUE_CW'(hbsf_pkg::QUEUE_DEPTH));

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ src/hbsf_back.sv @@
// back part: serializes flags and data with zero insertion into the output register
module hbsf_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  hbsf_pkg::item_t         head,
	input  hbsf_pkg::queue_status_t qstat,
	output logic                    pop,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [7:0]              out_data,
	output logic                    out_last
);

	hbsf_pkg::state_t                  state_q, state_d;
	logic [hbsf_pkg::CNT_W-1:0]        cnt_q, cnt_d;
	logic [hbsf_pkg::RUN_W-1:0]        ones_q, ones_d;
	hbsf_pkg::item_t                   cur_q;
	logic                              valid_q;
	logic                              line_q, flag_q, stuff_q, last_q;

	logic adv;
	logic emit, e_line, e_flag, e_stuff, e_last;
	logic done, end_data, dbit;

	assign adv = !valid_q || out_ready;
	assign dbit = cur_q.data_byte[cnt_q];

	always_comb begin
		state_d = state_q;
		cnt_d = cnt_q;
		ones_d = ones_q;
		emit = 1'b0;
		e_line = 1'b0;
		e_flag = 1'b0;
		e_stuff = 1'b0;
		e_last = 1'b0;
		done = 1'b0;
		end_data = 1'b0;
		pop = 1'b0;

		unique case (state_q)
			hbsf_pkg::ST_IDLE: begin
			end
			hbsf_pkg::ST_OPEN: begin
				if (adv) begin
					emit = 1'b1;
					e_line = hbsf_pkg::FLAG_PATTERN[cnt_q];
					e_flag = 1'b1;
					ones_d = '0;
					if (cnt_q == '0) begin
						state_d = hbsf_pkg::ST_DATA;
						cnt_d = hbsf_pkg::MSB_INDEX;
					end else begin
						cnt_d = cnt_q - 1'b1;
					end
				end
			end
			hbsf_pkg::ST_DATA: begin
				if (adv) begin
					emit = 1'b1;
					e_line = dbit;
					if (dbit && (ones_q == hbsf_pkg::RUN_LIMIT - 1'b1)) begin
						// fifth one in a row, a zero goes in next
						state_d = hbsf_pkg::ST_STUFF;
						ones_d = '0;
					end else begin
						ones_d = dbit ? ones_q + 1'b1 : '0;
						if (cnt_q == '0) begin
							end_data = 1'b1;
						end else begin
							cnt_d = cnt_q - 1'b1;
						end
					end
				end
			end
			hbsf_pkg::ST_STUFF: begin
				if (adv) begin
					emit = 1'b1;
					e_stuff = 1'b1;
					ones_d = '0;
					if (cnt_q == '0) begin
						end_data = 1'b1;
					end else begin
						state_d = hbsf_pkg::ST_DATA;
						cnt_d = cnt_q - 1'b1;
					end
				end
			end
			hbsf_pkg::ST_CLOSE: begin
				if (adv) begin
					emit = 1'b1;
					e_line = hbsf_pkg::FLAG_PATTERN[cnt_q];
					e_flag = 1'b1;
					ones_d = '0;
					if (cnt_q == '0) begin
						done = 1'b1;
						e_last = 1'b1;
					end else begin
						cnt_d = cnt_q - 1'b1;
					end
				end
			end
			default: begin
				state_d = hbsf_pkg::ST_IDLE;
			end
		endcase

		if (end_data) begin
			if (cur_q.end_of_frame) begin
				state_d = hbsf_pkg::ST_CLOSE;
				cnt_d = hbsf_pkg::MSB_INDEX;
			end else begin
				done = 1'b1;
				e_last = 1'b1;
			end
		end

		// next byte starts right behind the last bit of this one
		if ((state_q == hbsf_pkg::ST_IDLE) || done) begin
			if (!qstat.empty) begin
				pop = 1'b1;
				state_d = head.open_flag ? hbsf_pkg::ST_OPEN : hbsf_pkg::ST_DATA;
				cnt_d = hbsf_pkg::MSB_INDEX;
			end else begin
				state_d = hbsf_pkg::ST_IDLE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hbsf_pkg::ST_IDLE;
			cnt_q <= '0;
			ones_q <= '0;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q <= cnt_d;
			ones_q <= ones_d;
			if (adv) begin
				valid_q <= emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
		end
		if (adv) begin
			line_q <= e_line;
			flag_q <= e_flag;
			stuff_q <= e_stuff;
			last_q <= e_last;
		end
	end

	assign out_valid = valid_q;
	assign out_last = last_q;

	always_comb begin
		out_data = '0;
		out_data[hbsf_pkg::TD_LINE_BIT] = line_q;
		out_data[hbsf_pkg::TD_FLAG_BIT] = flag_q;
		out_data[hbsf_pkg::TD_STUFF_BIT] = stuff_q;
	end

endmodule

@@ src/hdlc_bit_stuffing_framer_unit.sv @@
// top level of the hdlc bit stuffing framer
// Each accepted byte yields 8 data bits, up to 2 inserted zeros, the 8-bit opening flag
// when it starts a frame and the 8-bit closing flag when tlast marks it as the frame end,
// so 8 to 26 line bits. The back part's serializer sends one line bit per cycle while
// m_axis_tready is high, so the byte rate follows the line bits each byte yields. A
// two-entry byte queue sits in front of the serializer, so new bytes are taken while the
// current one is still going out; m_axis_tlast marks the last line bit of each byte.
module hdlc_bit_stuffing_framer_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
	input  logic       s_axis_tlast,   // end_of_frame
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [0] line_bit, [1] is_flag_bit, [2] is_stuffed_bit, rest 0
	output logic       m_axis_tlast    // last_of_run
);

	logic                    push, pop;
	hbsf_pkg::item_t         push_item, head;
	hbsf_pkg::queue_status_t qstat;

	hbsf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_byte   (s_axis_tdata),
		.in_eof    (s_axis_tlast),
		.qstat     (qstat),
		.in_ready  (s_axis_tready),
		.push      (push),
		.push_item (push_item)
	);

	hbsf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.qstat     (qstat)
	);

	hbsf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.qstat     (qstat),
		.pop       (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_last  (m_axis_tlast)
	);

endmodule

@@ src/hbsf_checker.sv @@
// port-level checks for the hdlc bit stuffing framer
module hbsf_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_axis_tvalid,
	input logic       s_axis_tready,
	input logic [7:0] s_axis_tdata,
	input logic       s_axis_tlast,
	input logic       m_axis_tvalid,
	input logic       m_axis_tready,
	input logic [7:0] m_axis_tdata,
	input logic       m_axis_tlast
);

	// a stalled input transaction holds its payload
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && !s_axis_tready |=>
			s_axis_tvalid && $stable(s_axis_tdata) && $stable(s_axis_tlast))
		else $error("input changed while stalled");

	// a stalled result holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("result changed while stalled");

	// an inserted zero is a plain zero outside any flag
	a_stuff_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[2] |-> !m_axis_tdata[0] && !m_axis_tdata[1])
		else $error("bad stuffed bit");

	// the closing flag ends on a zero
	a_flag_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[1] && m_axis_tlast |-> !m_axis_tdata[0])
		else $error("closing flag ends on a one");

	// unused result bits stay zero
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[7:3] == 5'd0)
		else $error("result padding not zero");

endmodule

bind hdlc_bit_stuffing_framer_unit hbsf_checker u_hbsf_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tdata  (s_axis_tdata),
	.s_axis_tlast  (s_axis_tlast),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);
